// ===== hdl/sitr_pkg.sv =====
package sitr_pkg;

	// Radix after clamping: 2 to 16 fits in five bits.
	typedef logic [4:0] radix_t;
	typedef logic [3:0] digit_t;

	localparam radix_t RADIX_MIN = 5'd2;
	localparam radix_t RADIX_MAX = 5'd16;

	// Restoring division retires this many quotient bits per cycle.
	localparam int DIV_STEPS = 8;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	localparam logic [7:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SIGN,
		BK_READ,
		BK_SEND
	} back_state_t;

endpackage

// ===== hdl/sitr_in_if.sv =====
interface sitr_in_if #(
	parameter int VALUE_BITS = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic [7:0]                   radix;

	modport source (output valid, value, radix, input ready);
	modport sink (input valid, value, radix, output ready);
endinterface

// ===== hdl/sitr_out_if.sv =====
interface sitr_out_if ();
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, out_char, last, input ready);
	modport sink (input valid, out_char, last, output ready);
endinterface

// ===== hdl/signed_integer_to_radix_ascii_core.sv =====
// Order of work: an input transaction passes the front-end register and the
// queue before division starts; the divider retires eight quotient bits per
// cycle for each digit; then the sign is sent when negative, the digit store
// is read, and one character leaves per cycle while the output accepts it.
// The back end takes no new item until the last character has been loaded.
// Reset: arst_n clears all control state asynchronously; no clearing pass.
module signed_integer_to_radix_ascii_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	sitr_in_if.sink    din,
	sitr_out_if.source dout
);
	import sitr_pkg::*;

	// Queue entry: sign, clamped radix and unsigned magnitude.
	localparam int QW = VALUE_BITS + 6;

	logic                  f_valid;
	logic                  f_ready;
	logic                  f_neg;
	radix_t                f_radix;
	logic [VALUE_BITS-1:0] f_mag;
	logic                  b_valid;
	logic                  b_ready;
	logic [QW-1:0]         b_data;

	// The front end takes one transaction per cycle while the queue has
	// room; it computes the sign, the unsigned magnitude and the clamped
	// radix, so the back end only has to divide and format.
	sitr_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_neg   (f_neg),
		.push_radix (f_radix),
		.push_mag   (f_mag)
	);

	// A two-entry queue lets new transactions arrive while the back end is
	// still dividing or waiting on the output side.
	sitr_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_neg, f_radix, f_mag}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	// The back end produces the digits least significant first into its
	// digit store, then reads them back in reverse through an output
	// register so that the text leaves most significant character first.
	sitr_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (b_valid),
		.q_ready (b_ready),
		.q_neg   (b_data[QW-1]),
		.q_radix (b_data[QW-2:VALUE_BITS]),
		.q_mag   (b_data[VALUE_BITS-1:0]),
		.dout    (dout)
	);
endmodule

// ===== hdl/sitr_front.sv =====
module sitr_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	sitr_in_if.sink                din,
	output logic                   push_valid,
	input  logic                   push_ready,
	output logic                   push_neg,
	output sitr_pkg::radix_t       push_radix,
	output logic [VALUE_BITS-1:0]  push_mag
);
	import sitr_pkg::*;

	logic                  vld_q;
	logic                  neg_q;
	radix_t                rad_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [VALUE_BITS-1:0] v;
	radix_t                rad_c;
	logic                  take;

	assign v = din.value;
	assign din.ready = !vld_q || push_ready;
	assign take = din.valid && din.ready;

	// Saturate the base into the supported range.
	always_comb begin
		if (din.radix < {3'b000, RADIX_MIN}) begin
			rad_c = RADIX_MIN;
		end else if (din.radix > {3'b000, RADIX_MAX}) begin
			rad_c = RADIX_MAX;
		end else begin
			rad_c = din.radix[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take) begin
			vld_q <= 1'b1;
		end else if (push_ready) begin
			vld_q <= 1'b0;
		end
	end

	// The most negative value negates to its own bit pattern, which read
	// unsigned is exactly its magnitude.
	always_ff @(posedge clk) begin
		if (take) begin
			neg_q <= v[VALUE_BITS-1];
			rad_q <= rad_c;
			mag_q <= v[VALUE_BITS-1] ? (~v + 1'b1) : v;
		end
	end

	assign push_valid = vld_q;
	assign push_neg   = neg_q;
	assign push_radix = rad_q;
	assign push_mag   = mag_q;
endmodule

// ===== hdl/sitr_fifo.sv =====
module sitr_fifo #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             wr;
	logic             rd;

	assign wr_ready = cnt_q != CW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= wr_data;
		end
	end
endmodule

// ===== hdl/sitr_back.sv =====
module sitr_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic                  q_neg,
	input  sitr_pkg::radix_t      q_radix,
	input  logic [VALUE_BITS-1:0] q_mag,
	sitr_out_if.source            dout
);
	import sitr_pkg::*;

	localparam int DIV_W  = ((VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int CHUNKS = DIV_W / DIV_STEPS;
	localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int IW     = $clog2(VALUE_BITS);
	localparam int CW     = $clog2(VALUE_BITS + 1);

	back_state_t    st_q, st_d;
	logic [DIV_W-1:0] a_q, a_w;
	logic [3:0]     rem_q;
	logic [4:0]     r_w;
	logic [4:0]     t_w;
	radix_t         rad_q;
	logic           neg_q;
	logic [CKW-1:0] ck_q;
	logic [CW-1:0]  cnt_q;
	logic [IW-1:0]  idx_q;
	digit_t         dstore_q [VALUE_BITS];
	digit_t         rd_q;
	logic           ov_q;
	logic [7:0]     oc_q;
	logic           ol_q;

	logic           out_free;
	logic           load;
	logic           digit_end;
	logic           div_done;
	logic           rd_en;
	logic [IW-1:0]  rd_addr;
	logic           out_ld;
	logic [7:0]     out_c;
	logic           out_l;

	// Eight restoring-division steps on the narrow remainder per cycle.
	always_comb begin
		a_w = a_q;
		r_w = {1'b0, rem_q};
		t_w = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t_w = {r_w[3:0], a_w[DIV_W-1]};
			a_w = {a_w[DIV_W-2:0], 1'b0};
			if (t_w >= rad_q) begin
				r_w    = t_w - rad_q;
				a_w[0] = 1'b1;
			end else begin
				r_w = t_w;
			end
		end
	end

	assign out_free  = !ov_q || dout.ready;
	assign digit_end = (st_q == BK_DIV) && (ck_q == '0);
	assign div_done  = digit_end && ((a_w == '0) || (cnt_q + 1'b1 == CW'(VALUE_BITS)));

	always_comb begin
		st_d    = st_q;
		q_ready = 1'b0;
		load    = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		out_ld  = 1'b0;
		out_c   = CHAR_MINUS;
		out_l   = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					load = 1'b1;
					st_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_done) begin
					st_d = neg_q ? BK_SIGN : BK_READ;
				end
			end
			BK_SIGN: begin
				if (out_free) begin
					out_ld = 1'b1;
					st_d   = BK_READ;
				end
			end
			BK_READ: begin
				rd_en = 1'b1;
				st_d  = BK_SEND;
			end
			BK_SEND: begin
				out_c = DIGIT_CHARS[rd_q];
				out_l = idx_q == '0;
				if (out_free) begin
					out_ld = 1'b1;
					if (idx_q == '0) begin
						st_d = BK_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q - 1'b1;
					end
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= '0;
				neg_q <= q_neg;
			end else if (digit_end) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_ld) begin
				ov_q <= 1'b1;
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q   <= DIV_W'(q_mag);
			rem_q <= '0;
			rad_q <= q_radix;
			ck_q  <= CKW'(CHUNKS - 1);
		end else if (st_q == BK_DIV) begin
			a_q <= a_w;
			if (digit_end) begin
				rem_q <= '0;
				ck_q  <= CKW'(CHUNKS - 1);
			end else begin
				rem_q <= r_w[3:0];
				ck_q  <= ck_q - 1'b1;
			end
		end
		if (div_done) begin
			idx_q <= cnt_q[IW-1:0];
		end else if (st_q == BK_SEND && out_ld && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
		if (out_ld) begin
			oc_q <= out_c;
			ol_q <= out_l;
		end
	end

	// Digit store: one write port during division, one registered read port.
	always_ff @(posedge clk) begin
		if (digit_end) begin
			dstore_q[cnt_q[IW-1:0]] <= r_w[3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= dstore_q[rd_addr];
		end
	end

	assign dout.valid    = ov_q;
	assign dout.out_char = oc_q;
	assign dout.last     = ol_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(VALUE_BITS))
		else $error("digit count exceeds the store depth");

	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_READ || st_q == BK_SEND) |-> (CW'(idx_q) < cnt_q))
		else $error("digit read beyond the digits written");

	a_end_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_SEND && st_d == BK_IDLE) |=> (ov_q && ol_q))
		else $error("text ended without a last character");

	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_SIGN && out_ld) |=> (oc_q == CHAR_MINUS && !ol_q))
		else $error("sign character not presented");
`endif
endmodule
